// ===== rtl/triangle_raster_depth_test_defines.svh =====
// assertion macros used by the checker file
`ifndef TRIANGLE_RASTER_DEPTH_TEST_DEFINES_SVH
`define TRIANGLE_RASTER_DEPTH_TEST_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define TRD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/trd_pkg.sv =====
// ----------------------------------------------------------------------------
// trd_pkg
// types and constants shared by the rasteriser controller and datapath
// ----------------------------------------------------------------------------
package trd_pkg;

    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic signed [25:0] DEPTH_CLEAR = -26'sd7679232;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture request and set up bounding box
        logic clr_step;   // write clear values at scan position
        logic rd_issue;   // issue colour read at pixel_index
        logic px_issue;   // issue depth read for current pixel, advance scan
        logic px_commit;  // compare and write pixel whose depth has returned
        logic res_load;   // latch result
    } t_cmd;

    // status back to controller
    typedef struct packed {
        logic scan_last;  // current position is the last of the scan
        logic box_empty;  // bounding box has no pixels
    } t_status;

endpackage

// ===== rtl/triangle_raster_depth_test.sv =====
// ----------------------------------------------------------------------------
// triangle_raster_depth_test
// edge-function triangle rasteriser with depth and colour stores
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// request   in         i_valid / o_stall  operation, vertices, colour, index
// result    out        o_valid / i_stall  read_colour, pixels_written
//
// a draw scans the bounding-box pixels one pixel a cycle through the single
// depth read port and skips the scan when the box is empty; a clear writes
// all width*height locations.
// after reset all width*height store locations are swept, requests stalled.
// a waiting result does not block acceptance of the next request.
module triangle_raster_depth_test #(
    parameter int PIX_COLS = 256,
    parameter int PIX_ROWS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_operation,
    input  logic signed [15:0]  i_ax,
    input  logic signed [15:0]  i_ay,
    input  logic signed [23:0]  i_az,
    input  logic signed [15:0]  i_bx,
    input  logic signed [15:0]  i_by_coord,
    input  logic signed [23:0]  i_bz,
    input  logic signed [15:0]  i_cx,
    input  logic signed [15:0]  i_cy,
    input  logic signed [23:0]  i_cz,
    input  logic [31:0]         i_fill_colour,
    input  logic [15:0]         i_pixel_index,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [31:0]         o_read_colour,
    output logic [16:0]         o_pixels_written
);

    trd_pkg::t_cmd    w_cmd;
    trd_pkg::t_status w_status;

    trd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    trd_datapath #(
        .PIX_COLS (PIX_COLS),
        .PIX_ROWS (PIX_ROWS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_operation      (i_operation),
        .i_ax             (i_ax),
        .i_ay             (i_ay),
        .i_az             (i_az),
        .i_bx             (i_bx),
        .i_by_coord       (i_by_coord),
        .i_bz             (i_bz),
        .i_cx             (i_cx),
        .i_cy             (i_cy),
        .i_cz             (i_cz),
        .i_fill_colour    (i_fill_colour),
        .i_pixel_index    (i_pixel_index),
        .o_read_colour    (o_read_colour),
        .o_pixels_written (o_pixels_written)
    );

endmodule

// ===== rtl/trd_ctrl.sv =====
// ----------------------------------------------------------------------------
// trd_ctrl
// sequencer for draw, clear and read requests
// ----------------------------------------------------------------------------
module trd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_operation,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    output trd_pkg::t_cmd       o_cmd,
    input  trd_pkg::t_status    i_status
);

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_DRAW, S_DRAIN, S_CLEAR, S_READ, S_RESULT, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   r_drain, n_drain;
    logic   r_clearing, n_clearing;

    assign o_valid = r_valid;
    // a result waiting in the output register does not hold up the next request
    assign o_stall = (r_state != S_IDLE) || r_clearing;

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_drain    = 1'b0;
        n_clearing = r_clearing;
        o_cmd      = '0;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (r_clearing) begin
                    o_cmd.clr_step = 1'b1;
                    if (i_status.scan_last) begin
                        n_clearing = 1'b0;
                    end
                end else if (i_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_operation)
                        trd_pkg::OP_DRAW:  n_state = S_SETUP;
                        trd_pkg::OP_CLEAR: n_state = S_CLEAR;
                        trd_pkg::OP_READ:  n_state = S_READ;
                        default:           n_state = S_RESULT;
                    endcase
                end
            end
            S_SETUP: begin
                n_state = i_status.box_empty ? S_RESULT : S_DRAW;
            end
            S_DRAW: begin
                o_cmd.px_issue  = 1'b1;
                o_cmd.px_commit = r_drain;
                n_drain         = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.px_commit = 1'b1;
                n_state         = S_RESULT;
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_RESULT;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RESULT;
            end
            S_RESULT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_valid || !i_stall) begin
                    o_cmd.res_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= 1'b0;
            r_drain    <= 1'b0;
            r_clearing <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_drain    <= n_drain;
            r_clearing <= n_clearing;
        end
    end

endmodule

// ===== rtl/trd_datapath.sv =====
// ----------------------------------------------------------------------------
// trd_datapath
// bounding box scan, edge tests, depth and colour stores
// ----------------------------------------------------------------------------
module trd_datapath #(
    parameter int PIX_COLS = 256,
    parameter int PIX_ROWS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trd_pkg::t_cmd       i_cmd,
    output trd_pkg::t_status    o_status,
    input  logic [1:0]          i_operation,
    input  logic signed [15:0]  i_ax,
    input  logic signed [15:0]  i_ay,
    input  logic signed [23:0]  i_az,
    input  logic signed [15:0]  i_bx,
    input  logic signed [15:0]  i_by_coord,
    input  logic signed [23:0]  i_bz,
    input  logic signed [15:0]  i_cx,
    input  logic signed [15:0]  i_cy,
    input  logic signed [23:0]  i_cz,
    input  logic [31:0]         i_fill_colour,
    input  logic [15:0]         i_pixel_index,
    output logic [31:0]         o_read_colour,
    output logic [16:0]         o_pixels_written
);

    localparam int XW    = $clog2(PIX_COLS + 1);
    localparam int YW    = $clog2(PIX_ROWS + 1);
    localparam int DEPTH = PIX_COLS * PIX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [25:0] r_depth_mem [DEPTH];
    logic [31:0]        r_colour_mem [DEPTH];

    logic [1:0]         r_op;
    logic signed [15:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [25:0] r_zsum;
    logic [31:0]        r_col;
    logic [XW-1:0]      r_x0, r_x1, r_x;
    logic [YW-1:0]      r_y1, r_y;
    logic [AW-1:0]      r_clr_addr;
    logic               r_rd_ok;
    logic [AW-1:0]      r_rd_idx;
    logic [31:0]        r_rd_data;
    logic [16:0]        r_count;
    logic               r_p_cov;
    logic [AW-1:0]      r_p_addr;
    logic signed [25:0] r_p_depth;
    logic [31:0]        r_res_colour;
    logic [16:0]        r_res_count;

    // truncate a Q12.4 value toward zero and clamp into [0, lim]
    function automatic logic [12:0] trunc_clamp(input logic signed [15:0] v,
                                                input logic [12:0] lim);
        logic signed [16:0] e;
        logic signed [16:0] t;
        // bias negatives so the arithmetic shift rounds toward zero
        e = 17'(v) + ((v < 0) ? 17'sd15 : 17'sd0);
        t = e >>> 4;
        if (t < 0) return 13'd0;
        if (t > $signed({4'b0000, lim})) return lim;
        return t[12:0];
    endfunction

    function automatic logic signed [15:0] min3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [15:0] max3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // edge value >= 1.0 in Q.8
    function automatic logic edge_ok(input logic signed [15:0] x1,
                                     input logic signed [15:0] y1,
                                     input logic signed [15:0] x2,
                                     input logic signed [15:0] y2,
                                     input logic signed [17:0] px,
                                     input logic signed [17:0] py);
        logic signed [36:0] v;
        v = 37'(px - 18'(x1)) * 37'(18'(y2) - 18'(y1))
          - 37'(py - 18'(y1)) * 37'(18'(x2) - 18'(x1));
        return v >= 37'sd256;
    endfunction

    logic [12:0] w_x0, w_x1, w_y0, w_y1;
    assign w_x0 = trunc_clamp(min3(i_ax, i_bx, i_cx), 13'(PIX_COLS));
    assign w_x1 = trunc_clamp(max3(i_ax, i_bx, i_cx), 13'(PIX_COLS));
    assign w_y0 = trunc_clamp(min3(i_ay, i_by_coord, i_cy), 13'(PIX_ROWS));
    assign w_y1 = trunc_clamp(max3(i_ay, i_by_coord, i_cy), 13'(PIX_ROWS));

    logic signed [17:0] w_px, w_py;
    logic               w_cov;
    logic [AW-1:0]      w_addr;
    logic               w_x_last, w_y_last, w_win, w_clr_last;
    assign w_px  = $signed({1'b0, 17'(r_x)}) * 18'sd16 + 18'sd8;
    assign w_py  = $signed({1'b0, 17'(r_y)}) * 18'sd16 + 18'sd8;
    assign w_cov = edge_ok(r_ax, r_ay, r_bx, r_by, w_px, w_py)
                && edge_ok(r_bx, r_by, r_cx, r_cy, w_px, w_py)
                && edge_ok(r_cx, r_cy, r_ax, r_ay, w_px, w_py);
    assign w_addr   = AW'(32'(r_y) * PIX_COLS + 32'(r_x));
    assign w_x_last = (r_x + 1'b1) >= r_x1;
    assign w_y_last = (r_y + 1'b1) >= r_y1;
    assign w_clr_last = (32'(r_clr_addr) == DEPTH - 1);
    assign w_win = r_p_cov && (r_zsum > r_p_depth);

    always_comb begin
        o_status.box_empty = (r_x0 >= r_x1) || (r_y >= r_y1);
        if (i_cmd.clr_step) begin
            o_status.scan_last = w_clr_last;
        end else begin
            o_status.scan_last = w_x_last && w_y_last;
        end
    end

    // stores: one write port, one read port each
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_depth_mem[r_clr_addr]  <= trd_pkg::DEPTH_CLEAR;
            r_colour_mem[r_clr_addr] <= '0;
        end else if (i_cmd.px_commit && w_win) begin
            r_depth_mem[r_p_addr]  <= r_zsum;
            r_colour_mem[r_p_addr] <= r_col;
        end
        r_p_depth <= r_depth_mem[w_addr];
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_colour_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_count    <= '0;
            r_p_cov    <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= w_clr_last ? '0 : r_clr_addr + 1'b1;
            end
            if (i_cmd.load) begin
                r_count <= '0;
            end else if (i_cmd.px_commit && w_win && r_count != trd_pkg::COUNT_MAX) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.px_issue) begin
                r_p_cov <= w_cov;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_ax     <= i_ax;
            r_ay     <= i_ay;
            r_bx     <= i_bx;
            r_by     <= i_by_coord;
            r_cx     <= i_cx;
            r_cy     <= i_cy;
            r_zsum   <= 26'(i_az) + 26'(i_bz) + 26'(i_cz);
            r_col    <= i_fill_colour;
            r_x0     <= XW'(w_x0);
            r_x1     <= XW'(w_x1);
            r_x      <= XW'(w_x0);
            r_y      <= YW'(w_y0);
            r_y1     <= YW'(w_y1);
            r_rd_ok  <= 32'(i_pixel_index) < DEPTH;
            r_rd_idx <= AW'(i_pixel_index);
        end else if (i_cmd.px_issue) begin
            if (w_x_last) begin
                r_x <= r_x0;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
        if (i_cmd.px_issue) begin
            r_p_addr <= w_addr;
        end
        if (i_cmd.res_load) begin
            r_res_colour <= (r_op == trd_pkg::OP_READ && r_rd_ok) ? r_rd_data : '0;
            r_res_count  <= (r_op == trd_pkg::OP_DRAW) ? r_count : '0;
        end
    end

    assign o_read_colour    = r_res_colour;
    assign o_pixels_written = r_res_count;

endmodule

// ===== rtl/trd_checker.sv =====
// ----------------------------------------------------------------------------
// trd_checker
// port-level checks on the rasteriser
// ----------------------------------------------------------------------------
`include "triangle_raster_depth_test_defines.svh"

module trd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_read_colour,
    input logic [16:0] o_pixels_written
);

    logic        w_req;
    logic        w_hold;
    logic [48:0] w_res;

    assign w_req  = i_valid && !o_stall;
    assign w_hold = o_valid && i_stall;
    assign w_res  = {o_read_colour, o_pixels_written};

    // o_stall is raised after an accepted request
    `TRD_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, w_req, o_stall, "request not held")
    // a held result keeps its payload
    `TRD_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, w_hold, o_valid && $stable(w_res), "result moved")
    // at most one result field is non-zero while o_valid is high
    `TRD_ASSERT_IMPL(a_one_field, i_clk, i_rst_n, o_valid, o_read_colour == '0 || o_pixels_written == '0, "both set")

endmodule

bind triangle_raster_depth_test trd_checker u_trd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_read_colour    (o_read_colour),
    .o_pixels_written (o_pixels_written)
);
